/* hdl/gregorian_date_arithmetic_core_assert.svh */
// Assertion macros for the date core; clock aclk, reset aresetn.
`ifndef GREGORIAN_DATE_ARITHMETIC_CORE_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_CORE_ASSERT_SVH

// Same-cycle implication.
`define GDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/gda_pkg.sv */
package gda_pkg;

    localparam int OFFSET_WIDTH = 21;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFFS_W  = 21;
    localparam int DIFF_W  = 22;
    localparam int STAT_W  = 2;
    localparam int ACC_W   = 24;
    localparam int PC_W    = 5;
    localparam int K_W     = 5;

    localparam int IN_YEAR_LO   = 0;
    localparam int IN_MONTH_LO  = IN_YEAR_LO + YEAR_W;
    localparam int IN_DAY_LO    = IN_MONTH_LO + MONTH_W;
    localparam int IN_OFFS_LO   = IN_DAY_LO + DAY_W;
    localparam int IN_OYEAR_LO  = IN_OFFS_LO + OFFS_W;
    localparam int IN_OMONTH_LO = IN_OYEAR_LO + YEAR_W;
    localparam int IN_ODAY_LO   = IN_OMONTH_LO + MONTH_W;
    localparam int IN_USED      = IN_ODAY_LO + DAY_W;
    localparam int S_DATA_W     = ((IN_USED + 7) / 8) * 8;

    localparam int OUT_USED = YEAR_W + MONTH_W + DAY_W + DIFF_W + 2;
    localparam int M_DATA_W = ((OUT_USED + 7) / 8) * 8;

    localparam logic [YEAR_W-1:0]         MAX_YEAR   = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0]        MONTHS     = MONTH_W'(12);
    localparam logic [MONTH_W-1:0]        FEBRUARY   = MONTH_W'(2);
    localparam logic signed [ACC_W-1:0]   SERIAL_END = ACC_W'(3652059);

    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    localparam logic [8:0] CUM_DAYS [16] = '{
        9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
    };

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_RANGE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {U400, U100, U4, U1} unit_t;

    typedef enum logic {MODE_TO, MODE_FROM} mode_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_LDP, OP_YLOOP, OP_ADDMD, OP_SAVE, OP_ADDOFF, OP_LDY,
        OP_MSET, OP_MLOOP, OP_EMIT0, OP_EMIT1, OP_EMITINV, OP_EMITRNG
    } op_t;

    typedef enum logic [2:0] {
        J_NONE, J_YM_BAD, J_DAY_BAD, J_K1_SECOND, J_K1_FIRST, J_RANGE
    } jump_t;

    typedef struct packed {
        op_t              op;
        jump_t            jump;
        unit_t            unit;
        mode_t            mode;
        logic [PC_W-1:0]  target;
    } uword_t;

    localparam logic [PC_W-1:0] PC_CHECK   = PC_W'(0);
    localparam logic [PC_W-1:0] PC_DIFF    = PC_W'(19);
    localparam logic [PC_W-1:0] PC_ERR_INV = PC_W'(20);
    localparam logic [PC_W-1:0] PC_ERR_RNG = PC_W'(21);

    function automatic logic [4:0] dim(input logic [MONTH_W-1:0] month, input logic leap);
        return MONTH_LEN[month] + 5'(month == FEBRUARY && leap);
    endfunction

    function automatic logic [8:0] unit_years(input unit_t u);
        logic [8:0] r;
        case (u)
            U400:    r = 9'd400;
            U100:    r = 9'd100;
            U4:      r = 9'd4;
            default: r = 9'd1;
        endcase
        return r;
    endfunction

    function automatic logic [17:0] unit_days(input unit_t u);
        logic [17:0] r;
        case (u)
            U400:    r = 18'd146097;
            U100:    r = 18'd36524;
            U4:      r = 18'd1461;
            default: r = 18'd365;
        endcase
        return r;
    endfunction

    function automatic uword_t mk(input op_t op, input jump_t jump, input unit_t unit,
                                  input mode_t mode, input logic [PC_W-1:0] target);
        uword_t w;
        w.op     = op;
        w.jump   = jump;
        w.unit   = unit;
        w.mode   = mode;
        w.target = target;
        return w;
    endfunction

    // Serial of a date: years via 400/100/4/1 blocks, then month table and day.
    // Offset: add, range check, then peel blocks back off and walk months.
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            5'd0:    w = mk(OP_NOP,     J_YM_BAD,    U400, MODE_TO,   PC_ERR_INV);
            5'd1:    w = mk(OP_LDP,     J_NONE,      U400, MODE_TO,   PC_CHECK);
            5'd2:    w = mk(OP_YLOOP,   J_NONE,      U400, MODE_TO,   PC_CHECK);
            5'd3:    w = mk(OP_YLOOP,   J_NONE,      U100, MODE_TO,   PC_CHECK);
            5'd4:    w = mk(OP_YLOOP,   J_NONE,      U4,   MODE_TO,   PC_CHECK);
            5'd5:    w = mk(OP_YLOOP,   J_NONE,      U1,   MODE_TO,   PC_CHECK);
            5'd6:    w = mk(OP_ADDMD,   J_DAY_BAD,   U400, MODE_TO,   PC_ERR_INV);
            5'd7:    w = mk(OP_NOP,     J_K1_SECOND, U400, MODE_TO,   PC_DIFF);
            5'd8:    w = mk(OP_SAVE,    J_K1_FIRST,  U400, MODE_TO,   PC_CHECK);
            5'd9:    w = mk(OP_ADDOFF,  J_NONE,      U400, MODE_TO,   PC_CHECK);
            5'd10:   w = mk(OP_NOP,     J_RANGE,     U400, MODE_TO,   PC_ERR_RNG);
            5'd11:   w = mk(OP_LDY,     J_NONE,      U400, MODE_FROM, PC_CHECK);
            5'd12:   w = mk(OP_YLOOP,   J_NONE,      U400, MODE_FROM, PC_CHECK);
            5'd13:   w = mk(OP_YLOOP,   J_NONE,      U100, MODE_FROM, PC_CHECK);
            5'd14:   w = mk(OP_YLOOP,   J_NONE,      U4,   MODE_FROM, PC_CHECK);
            5'd15:   w = mk(OP_YLOOP,   J_NONE,      U1,   MODE_FROM, PC_CHECK);
            5'd16:   w = mk(OP_MSET,    J_NONE,      U400, MODE_FROM, PC_CHECK);
            5'd17:   w = mk(OP_MLOOP,   J_NONE,      U400, MODE_FROM, PC_CHECK);
            5'd18:   w = mk(OP_EMIT0,   J_NONE,      U400, MODE_FROM, PC_CHECK);
            5'd19:   w = mk(OP_EMIT1,   J_NONE,      U400, MODE_TO,   PC_CHECK);
            5'd20:   w = mk(OP_EMITINV, J_NONE,      U400, MODE_TO,   PC_CHECK);
            5'd21:   w = mk(OP_EMITRNG, J_NONE,      U400, MODE_TO,   PC_CHECK);
            default: w = mk(OP_EMITINV, J_NONE,      U400, MODE_TO,   PC_CHECK);
        endcase
        return w;
    endfunction

endpackage

/* hdl/gregorian_date_arithmetic_core.sv */
// channel | dir | handshake           | payload
// s_*     | in  | s_tvalid / s_tready | tdata: both dates and day offset, tuser: kind
// m_*     | out | m_tvalid / m_tready | tdata: date, day distance, flags, tuser: status
// One request at a time; the run time of an offset or a difference is set by the
// subtract loops of the year/month step unit under the microcode.
// Reset (aresetn low, synchronous) idles the sequencer and empties the output register.
// A finished result waits in the output register while the next word is accepted;
// the sequencer holds on its emit step while that register is full and m_tready is low.
`include "gregorian_date_arithmetic_core_assert.svh"

module gregorian_date_arithmetic_core
    import gda_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // year, month, day, offset_days, other_year, other_month, other_day, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    // kind
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_year, out_month, out_day, days_between, first_is_greater, dates_equal, zero pad
    output logic [M_DATA_W-1:0] m_tdata,
    // status
    output logic [STAT_W-1:0]   m_tuser
);

    logic                             kind_reg;
    logic [YEAR_W-1:0]                y1_reg, y2_reg;
    logic [MONTH_W-1:0]               m1_reg, m2_reg;
    logic [DAY_W-1:0]                 d1_reg, d2_reg;
    logic signed [OFFSET_WIDTH-1:0]   off_reg;

    logic                             busy_reg, busy_next;
    logic [PC_W-1:0]                  pc_reg, pc_next;
    logic                             sel_reg, sel_next;
    logic [YEAR_W-1:0]                y_reg, y_next;
    logic [MONTH_W-1:0]               m_reg, m_next;
    logic signed [ACC_W-1:0]          a_reg, a_next;
    logic signed [ACC_W-1:0]          sa_reg, sa_next;
    logic [K_W-1:0]                   k_reg, k_next;
    logic                             cent3_reg, cent3_next;
    logic                             c24_reg, c24_next;
    logic                             leap_reg, leap_next;

    logic                             m_tvalid_reg, m_tvalid_next;
    logic [YEAR_W-1:0]                oy_reg, oy_next;
    logic [MONTH_W-1:0]               om_reg, om_next;
    logic [DAY_W-1:0]                 od_reg, od_next;
    logic [DIFF_W-1:0]                diff_reg, diff_next;
    logic                             gt_reg, gt_next;
    logic                             eq_reg, eq_next;
    status_t                          st_reg, st_next;

    uword_t                           uw;
    logic                             accept;
    logic [YEAR_W-1:0]                cy;
    logic [MONTH_W-1:0]               cm;
    logic [DAY_W-1:0]                 cd;
    logic [YEAR_W-1:0]                yyrs;
    logic signed [ACC_W-1:0]          ydays;
    logic signed [ACC_W-1:0]          mdays;
    logic signed [ACC_W-1:0]          off_ext;
    logic [4:0]                       cur_len;
    logic                             capped;
    logic                             take_y;
    logic                             take_m;
    logic                             jump_hit;
    logic                             emit_op;
    logic                             emit_ok;
    logic                             hold_pc;
    logic                             first_gt;

    assign uw       = ucode(pc_reg);
    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg;

    assign cy = sel_reg ? y2_reg : y1_reg;
    assign cm = sel_reg ? m2_reg : m1_reg;
    assign cd = sel_reg ? d2_reg : d1_reg;

    assign yyrs    = YEAR_W'(unit_years(uw.unit));
    assign ydays   = ACC_W'(unit_days(uw.unit));
    assign mdays   = ACC_W'(dim(m_reg, leap_reg));
    assign off_ext = ACC_W'(off_reg);
    assign cur_len = dim(cm, leap_reg);
    assign capped  = (uw.unit == U100 || uw.unit == U1) && k_reg == K_W'(3);
    assign take_y  = (uw.mode == MODE_TO) ? (y_reg >= yyrs) : (!capped && a_reg >= ydays);
    assign take_m  = m_reg < MONTHS && a_reg >= mdays;
    assign first_gt = sa_reg > a_reg;

    assign emit_op = uw.op == OP_EMIT0 || uw.op == OP_EMIT1 ||
                     uw.op == OP_EMITINV || uw.op == OP_EMITRNG;
    assign emit_ok = !m_tvalid_reg || m_tready;
    assign hold_pc = (uw.op == OP_YLOOP && take_y) || (uw.op == OP_MLOOP && take_m);

    always_comb begin
        case (uw.jump)
            J_YM_BAD:    jump_hit = cy == '0 || cy > MAX_YEAR || cm == '0 || cm > MONTHS;
            J_DAY_BAD:   jump_hit = cd == '0 || cd > cur_len;
            J_K1_SECOND: jump_hit = kind_reg && sel_reg;
            J_K1_FIRST:  jump_hit = kind_reg && !sel_reg;
            J_RANGE:     jump_hit = a_reg < 0 || a_reg >= SERIAL_END;
            default:     jump_hit = 1'b0;
        endcase
    end

    always_comb begin
        busy_next     = busy_reg;
        pc_next       = pc_reg;
        sel_next      = sel_reg;
        y_next        = y_reg;
        m_next        = m_reg;
        a_next        = a_reg;
        sa_next       = sa_reg;
        k_next        = k_reg;
        cent3_next    = cent3_reg;
        c24_next      = c24_reg;
        leap_next     = leap_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        oy_next       = oy_reg;
        om_next       = om_reg;
        od_next       = od_reg;
        diff_next     = diff_reg;
        gt_next       = gt_reg;
        eq_next       = eq_reg;
        st_next       = st_reg;

        if (busy_reg && !(emit_op && !emit_ok)) begin
            case (uw.op)
                OP_LDP: begin
                    y_next = cy - YEAR_W'(1);
                    a_next = '0;
                    k_next = '0;
                end
                OP_YLOOP: begin
                    if (take_y) begin
                        k_next = k_reg + K_W'(1);
                        if (uw.mode == MODE_TO) begin
                            y_next = y_reg - yyrs;
                            a_next = a_reg + ydays;
                        end else begin
                            y_next = y_reg + yyrs;
                            a_next = a_reg - ydays;
                        end
                    end else begin
                        k_next = '0;
                        case (uw.unit)
                            U100:    cent3_next = k_reg == K_W'(3);
                            U4:      c24_next = k_reg == K_W'(24);
                            U1:      leap_next = k_reg == K_W'(3) && (!c24_reg || cent3_reg);
                            default: ;
                        endcase
                    end
                end
                OP_ADDMD: begin
                    a_next = a_reg + ACC_W'(CUM_DAYS[cm])
                           + ACC_W'(leap_reg && cm > FEBRUARY) + ACC_W'(cd) - ACC_W'(1);
                end
                OP_SAVE: begin
                    sa_next  = a_reg;
                    sel_next = kind_reg;
                end
                OP_ADDOFF: begin
                    a_next = a_reg + off_ext;
                end
                OP_LDY: begin
                    y_next = YEAR_W'(1);
                    k_next = '0;
                end
                OP_MSET: begin
                    m_next = MONTH_W'(1);
                end
                OP_MLOOP: begin
                    if (take_m) begin
                        a_next = a_reg - mdays;
                        m_next = m_reg + MONTH_W'(1);
                    end
                end
                OP_EMIT0: begin
                    oy_next   = y_reg;
                    om_next   = m_reg;
                    od_next   = a_reg[DAY_W-1:0] + DAY_W'(1);
                    diff_next = '0;
                    gt_next   = 1'b0;
                    eq_next   = 1'b0;
                    st_next   = STAT_OK;
                end
                OP_EMIT1: begin
                    oy_next   = '0;
                    om_next   = '0;
                    od_next   = '0;
                    diff_next = first_gt ? DIFF_W'(sa_reg - a_reg) : DIFF_W'(a_reg - sa_reg);
                    gt_next   = first_gt;
                    eq_next   = sa_reg == a_reg;
                    st_next   = STAT_OK;
                end
                OP_EMITINV, OP_EMITRNG: begin
                    oy_next   = '0;
                    om_next   = '0;
                    od_next   = '0;
                    diff_next = '0;
                    gt_next   = 1'b0;
                    eq_next   = 1'b0;
                    st_next   = (uw.op == OP_EMITINV) ? STAT_INVALID : STAT_RANGE;
                end
                default: ;
            endcase

            if (emit_op) begin
                m_tvalid_next = 1'b1;
                busy_next     = 1'b0;
                pc_next       = PC_CHECK;
            end else if (!hold_pc) begin
                pc_next = jump_hit ? uw.target : pc_reg + PC_W'(1);
            end
        end

        if (accept) begin
            busy_next = 1'b1;
            pc_next   = PC_CHECK;
            sel_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            pc_reg       <= PC_CHECK;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            pc_reg       <= pc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg   <= sel_next;
        y_reg     <= y_next;
        m_reg     <= m_next;
        a_reg     <= a_next;
        sa_reg    <= sa_next;
        k_reg     <= k_next;
        cent3_reg <= cent3_next;
        c24_reg   <= c24_next;
        leap_reg  <= leap_next;
        oy_reg    <= oy_next;
        om_reg    <= om_next;
        od_reg    <= od_next;
        diff_reg  <= diff_next;
        gt_reg    <= gt_next;
        eq_reg    <= eq_next;
        st_reg    <= st_next;
        if (accept) begin
            kind_reg <= s_tuser;
            y1_reg   <= s_tdata[IN_YEAR_LO +: YEAR_W];
            m1_reg   <= s_tdata[IN_MONTH_LO +: MONTH_W];
            d1_reg   <= s_tdata[IN_DAY_LO +: DAY_W];
            off_reg  <= s_tdata[IN_OFFS_LO +: OFFSET_WIDTH];
            y2_reg   <= s_tdata[IN_OYEAR_LO +: YEAR_W];
            m2_reg   <= s_tdata[IN_OMONTH_LO +: MONTH_W];
            d2_reg   <= s_tdata[IN_ODAY_LO +: DAY_W];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - OUT_USED){1'b0}}, eq_reg, gt_reg, diff_reg,
                       od_reg, om_reg, oy_reg};
    assign m_tuser  = st_reg;

    `GDA_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, busy_reg, "accepted word did not start the sequencer")
    `GDA_ASSERT_NOW(a_idle_pc, !busy_reg, pc_reg == PC_CHECK, "idle sequencer off its entry step")
    `GDA_ASSERT_NOW(a_second_pass_kind, busy_reg && sel_reg, kind_reg, "second date pass on an offset request")
    `GDA_ASSERT_NOW(a_equal_zero, m_tvalid_reg && eq_reg, diff_reg == '0 && st_reg == STAT_OK, "equal dates with nonzero distance")
    `GDA_ASSERT_NOW(a_month_walk, busy_reg && uw.op == OP_MLOOP, m_reg != '0 && m_reg <= MONTHS, "month walk out of range")

endmodule
